FILE: src/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types and constants for the printf conversion formatter.
// ----------------------------------------------------------------------------
package pcf_pkg;

   typedef enum logic [2:0] {
      CONV_C    = 3'd0,
      CONV_D    = 3'd1,
      CONV_U    = 3'd2,
      CONV_X    = 3'd3,
      CONV_XU   = 3'd4,
      CONV_P    = 3'd5,
      CONV_PCT  = 3'd6,
      CONV_NONE = 3'd7
   } conv_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_CONV = 2'd1,
      ST_EMIT = 2'd2
   } state_type;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;

   // hex digit to ascii, lower or upper case letters
   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d < 4'd10) c = CH_ZERO + {4'd0, d};
      else if (upper) c = 8'h37 + {4'd0, d};
      else c = 8'h57 + {4'd0, d};
      return c;
   endfunction

endpackage

FILE: src/pcf_digit_unit.sv
// ----------------------------------------------------------------------------
// pcf_digit_unit
// Radix converter: one hex digit per cycle, or one decimal digit per full pass
// of bit-serial restoring division by ten over the whole dividend.
// ----------------------------------------------------------------------------
module pcf_digit_unit
   import pcf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        decimal,
   input  logic [63:0] magnitude,
   output logic        dig_valid,
   output logic [3:0]  dig_value,
   output logic        done
);

   logic [63:0] quot_ff, quot_in;
   logic [3:0]  rem_ff, rem_in;
   logic [6:0]  bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        dec_ff, dec_in;
   logic [4:0]  trial;

   assign trial = {rem_ff, quot_ff[63]};

   // one step of conversion per cycle
   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      busy_in = busy_ff;
      dec_in = dec_ff;
      dig_valid = 1'b0;
      dig_value = 4'd0;
      done = 1'b0;
      if (start) begin
         quot_in = magnitude;
         rem_in = 4'd0;
         bit_in = 7'd0;
         busy_in = 1'b1;
         dec_in = decimal;
      end else if (busy_ff) begin
         if (!dec_ff) begin
            dig_valid = 1'b1;
            dig_value = quot_ff[3:0];
            quot_in = {4'd0, quot_ff[63:4]};
            if (quot_in == 64'd0) begin
               busy_in = 1'b0;
               done = 1'b1;
            end
         end else begin
            // shift in one dividend bit, subtract ten when it fits
            if (trial >= 5'd10) begin
               rem_in = 4'(trial - 5'd10);
               quot_in = {quot_ff[62:0], 1'b1};
            end else begin
               rem_in = trial[3:0];
               quot_in = {quot_ff[62:0], 1'b0};
            end
            bit_in = bit_ff + 7'd1;
            if (bit_ff == 7'd63) begin
               dig_valid = 1'b1;
               dig_value = rem_in;
               rem_in = 4'd0;
               bit_in = 7'd0;
               if (quot_in == 64'd0) begin
                  busy_in = 1'b0;
                  done = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      dec_ff <= dec_in;
   end

endmodule

FILE: src/printf_conversion_formatter_unit.sv
// ----------------------------------------------------------------------------
// printf_conversion_formatter_unit
// Formats one parsed printf conversion into a stream of characters.
// ----------------------------------------------------------------------------
// One conversion at a time. Hex digits come one per cycle; decimal digits
// come from bit-serial division by ten, one digit per full pass. Characters
// then leave one per cycle while rsp_ready is high.
module printf_conversion_formatter_unit
   import pcf_pkg::*;
#(
   parameter int MAX_FIELD = 62
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [63:0] req_arg_value,
   input  logic        req_left_justify,
   input  logic        req_zero_pad,
   input  logic        req_alt_form,
   input  logic        req_space_sign,
   input  logic        req_plus_sign,
   input  logic [5:0]  req_field_width,
   input  logic        req_has_precision,
   input  logic [5:0]  req_precision_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_no_char,
   output logic        rsp_last_char
);

   localparam logic [5:0] MAXF = 6'(MAX_FIELD);

   state_type state_ff, state_in;

   // captured request
   conv_type   type_ff;
   logic       lj_ff, zp_ff, hp_ff, upper_ff;
   logic [5:0] w_ff, prec_ff;
   logic [7:0] char_ff;
   logic [7:0] pre0_ff, pre1_ff;
   logic [1:0] plen_ff;

   // digit store, most significant first after reversal
   logic [3:0] dig_ff [20];
   logic [4:0] nd_ff, nd_in;

   // emission counters
   logic [6:0] pos_ff, pos_in;
   logic [6:0] total;
   logic [6:0] pad, zeros, content, lead;

   // output register
   logic       ov_ff, ov_in;
   logic [7:0] oc_ff, oc_in;
   logic       onc_ff, onc_in, ol_ff, ol_in;

   // decoded request
   logic [5:0]  w_sat, p_sat;
   logic [31:0] low32, neg32;
   logic [63:0] mag;
   logic        neg;
   logic        start;

   logic        du_valid, du_done;
   logic [3:0]  du_value;

   assign w_sat = (req_field_width > MAXF) ? MAXF : req_field_width;
   assign p_sat = (req_precision_value > MAXF) ? MAXF : req_precision_value;
   assign low32 = req_arg_value[31:0];
   assign neg32 = 32'd0 - low32;
   assign neg = (conv_type'(req_type) == CONV_D) && low32[31];

   // magnitude selection
   always_comb begin
      case (conv_type'(req_type))
         CONV_D:  mag = neg ? {32'd0, neg32} : {32'd0, low32};
         CONV_P:  mag = req_arg_value;
         default: mag = {32'd0, low32};
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE) && !ov_ff;
   assign start = req_valid && req_ready;

   logic is_num;
   assign is_num = (conv_type'(req_type) inside {CONV_D, CONV_U, CONV_X, CONV_XU, CONV_P});

   pcf_digit_unit u_digit (
      .clock     (clock),
      .reset     (reset),
      .start     (start && is_num && !(req_has_precision && p_sat == 6'd0 && mag == 64'd0)),
      .decimal   (conv_type'(req_type) == CONV_D || conv_type'(req_type) == CONV_U),
      .magnitude (mag),
      .dig_valid (du_valid),
      .dig_value (du_value),
      .done      (du_done)
   );

   // capture request fields
   always_ff @(posedge clock) begin
      if (start) begin
         type_ff <= conv_type'(req_type);
         lj_ff <= req_left_justify;
         zp_ff <= req_zero_pad;
         hp_ff <= req_has_precision;
         w_ff <= w_sat;
         prec_ff <= p_sat;
         upper_ff <= conv_type'(req_type) == CONV_XU;
         char_ff <= (conv_type'(req_type) == CONV_PCT) ? CH_PCT : req_arg_value[7:0];
         pre0_ff <= CH_ZERO;
         pre1_ff <= CH_LX;
         plen_ff <= 2'd0;
         case (conv_type'(req_type)) inside
            CONV_D: begin
               if (neg) begin
                  pre0_ff <= CH_MINUS; plen_ff <= 2'd1;
               end else if (req_plus_sign) begin
                  pre0_ff <= CH_PLUS; plen_ff <= 2'd1;
               end else if (req_space_sign) begin
                  pre0_ff <= CH_SPACE; plen_ff <= 2'd1;
               end
            end
            CONV_P: plen_ff <= 2'd2;
            CONV_X, CONV_XU: begin
               if (req_alt_form && low32 != 32'd0) plen_ff <= 2'd2;
               if (conv_type'(req_type) == CONV_XU) pre1_ff <= CH_UX;
            end
            default: ;
         endcase
      end
      // digits arrive least significant first; shift store up
      if (du_valid) begin
         for (int i = 19; i > 0; i--) dig_ff[i] <= dig_ff[i-1];
         dig_ff[0] <= du_value;
      end
   end

   // field layout
   logic [6:0] ndx;
   always_comb begin
      case (type_ff) inside
         CONV_C, CONV_PCT: ndx = (hp_ff && prec_ff == 6'd0) ? 7'd0 : 7'd1;
         CONV_NONE:        ndx = 7'd0;
         default:          ndx = {2'd0, nd_ff};
      endcase
      zeros = 7'd0;
      if (type_ff != CONV_C && type_ff != CONV_PCT && type_ff != CONV_NONE) begin
         if (hp_ff) begin
            if ({1'b0, prec_ff} > ndx) zeros = {1'b0, prec_ff} - ndx;
         end else if (zp_ff && !lj_ff) begin
            if ({1'b0, w_ff} > {5'd0, plen_ff} + ndx)
               zeros = {1'b0, w_ff} - {5'd0, plen_ff} - ndx;
         end
      end
      content = {5'd0, plen_ff} + zeros + ndx;
      pad = ({1'b0, w_ff} > content) ? {1'b0, w_ff} - content : 7'd0;
      total = content + pad;
      lead = lj_ff ? 7'd0 : pad;
   end

   // character at the current position
   logic [7:0] cur;
   logic [6:0] rel;
   logic [4:0] di;
   always_comb begin
      rel = 7'd0;
      di = 5'd0;
      if (pos_ff < lead) cur = CH_SPACE;
      else if (pos_ff < lead + {5'd0, plen_ff})
         cur = (pos_ff == lead) ? pre0_ff : pre1_ff;
      else if (pos_ff < lead + {5'd0, plen_ff} + zeros) cur = CH_ZERO;
      else if (pos_ff < lead + content) begin
         rel = pos_ff - lead - {5'd0, plen_ff} - zeros;
         di = 5'(rel);
         if (type_ff == CONV_C || type_ff == CONV_PCT) cur = char_ff;
         else cur = digit_char(dig_ff[di], upper_ff);
      end else cur = CH_SPACE;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      nd_in = nd_ff;
      pos_in = pos_ff;
      ov_in = ov_ff && !rsp_ready;
      oc_in = oc_ff;
      onc_in = onc_ff;
      ol_in = ol_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               nd_in = 5'd0;
               pos_in = 7'd0;
               if (is_num && !(req_has_precision && p_sat == 6'd0 && mag == 64'd0))
                  state_in = ST_CONV;
               else state_in = ST_EMIT;
            end
         end
         ST_CONV: begin
            if (du_valid) nd_in = nd_ff + 5'd1;
            if (du_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;
               if (total == 7'd0) begin
                  oc_in = 8'd0; onc_in = 1'b1; ol_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  oc_in = cur; onc_in = 1'b0;
                  ol_in = (pos_ff + 7'd1 == total);
                  pos_in = pos_ff + 7'd1;
                  if (ol_in) state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
      end
      nd_ff <= nd_in;
      pos_ff <= pos_in;
      oc_ff <= oc_in;
      onc_ff <= onc_in;
      ol_ff <= ol_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_out_char = oc_ff;
   assign rsp_no_char = onc_ff;
   assign rsp_last_char = ol_ff;

endmodule

FILE: tb/sv/printf_conversion_formatter_unit_test.sv
// ----------------------------------------------------------------------------
// printf_conversion_formatter_unit_test
// Drives parsed printf conversions into the formatter and checks every
// character word against a local model of the field layout.
// ----------------------------------------------------------------------------
module printf_conversion_formatter_unit_test;
   import pcf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_FIELD = 62;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct packed {
      conv_type    kind;
      logic [63:0] arg;
      logic        lj;
      logic        zp;
      logic        alt;
      logic        sp;
      logic        pl;
      logic [5:0]  width;
      logic        hp;
      logic [5:0]  prec;
   } conv_req;

   typedef struct packed {
      logic [7:0] ch;
      logic       empty;
      logic       last;
   } char_word;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_type;
   logic [63:0] req_arg_value;
   logic        req_left_justify;
   logic        req_zero_pad;
   logic        req_alt_form;
   logic        req_space_sign;
   logic        req_plus_sign;
   logic [5:0]  req_field_width;
   logic        req_has_precision;
   logic [5:0]  req_precision_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_char;
   logic        rsp_no_char;
   logic        rsp_last_char;

   conv_req  pending_convs[$];
   char_word expected_chars[$];
   bit       failed;
   bit       calm;
   int       cycle_count;

   printf_conversion_formatter_unit #(.MAX_FIELD(MAX_FIELD)) DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_field(logic [5:0] v);
      return (v > MAX_FIELD) ? MAX_FIELD : int'(v);
   endfunction

   // build the formatted field and queue its characters
   function automatic void format_conversion(conv_req r);
      byte unsigned pre[$];
      byte unsigned dig[$];
      byte unsigned line[$];
      logic [63:0]  mag;
      int           base;
      bit           upper;
      int           w, p, zeros, content, pad, n;
      char_word     cw;
      w = clamp_field(r.width);
      p = clamp_field(r.prec);
      zeros = 0;
      base = 16;
      upper = 1'b0;
      if (r.kind == CONV_C || r.kind == CONV_PCT) begin
         if (!(r.hp && p == 0))
            dig.push_back((r.kind == CONV_C) ? r.arg[7:0] : CH_PCT);
      end else if (r.kind != CONV_NONE) begin
         if (r.kind == CONV_D) begin
            base = 10;
            if (r.arg[31]) begin
               mag = {32'd0, -r.arg[31:0]};
               pre.push_back(CH_MINUS);
            end else begin
               mag = {32'd0, r.arg[31:0]};
               if (r.pl) pre.push_back(CH_PLUS);
               else if (r.sp) pre.push_back(CH_SPACE);
            end
         end else if (r.kind == CONV_P) begin
            mag = r.arg;
            pre.push_back(CH_ZERO);
            pre.push_back(CH_LX);
         end else begin
            mag = {32'd0, r.arg[31:0]};
            if (r.kind == CONV_U) base = 10;
            upper = (r.kind == CONV_XU);
            if (r.alt && mag != 0 && r.kind != CONV_U) begin
               pre.push_back(CH_ZERO);
               pre.push_back(upper ? CH_UX : CH_LX);
            end
         end
         if (!(r.hp && p == 0 && mag == 0)) begin
            do begin
               dig.push_front(digit_char(4'(mag % base), upper));
               mag = mag / base;
            end while (mag != 0);
         end
         if (r.hp) begin
            if (p > dig.size()) zeros = p - dig.size();
         end else if (r.zp && !r.lj) begin
            if (w > pre.size() + dig.size()) zeros = w - pre.size() - dig.size();
         end
      end
      content = pre.size() + zeros + dig.size();
      pad = (w > content) ? w - content : 0;
      if (!r.lj) repeat (pad) line.push_back(CH_SPACE);
      foreach (pre[i]) line.push_back(pre[i]);
      repeat (zeros) line.push_back(CH_ZERO);
      foreach (dig[i]) line.push_back(dig[i]);
      if (r.lj) repeat (pad) line.push_back(CH_SPACE);
      if (line.size() == 0) begin
         cw = '{ch: 8'd0, empty: 1'b1, last: 1'b1};
         expected_chars.push_back(cw);
         return;
      end
      n = (line.size() > 64) ? 64 : line.size();
      for (int k = 0; k < n; k++) begin
         cw = '{ch: line[k], empty: 1'b0, last: (k == n - 1)};
         expected_chars.push_back(cw);
      end
   endfunction

   // random conversion, mostly small widths and precisions, with mixed values and some extremes
   function automatic conv_req random_conv();
      conv_req r;
      r.kind  = conv_type'($urandom_range(0, 7) == 7 && $urandom_range(0, 3) != 0 ?
                           $urandom_range(0, 6) : $urandom_range(0, 7));
      case ($urandom_range(0, 4))
         0: r.arg = {$urandom, $urandom};
         1: r.arg = 64'($urandom_range(0, 20));
         2: r.arg = {32'($urandom), 32'hFFFF_FFFF - 32'($urandom_range(0, 20))};
         3: r.arg = {$urandom, 1'b1, 31'($urandom)};
         default: r.arg = {32'($urandom), 32'($urandom)} >> $urandom_range(0, 63);
      endcase
      {r.lj, r.zp, r.alt, r.sp, r.pl, r.hp} = 6'($urandom);
      r.width = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 14));
      r.prec  = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12));
      return r;
   endfunction

   function automatic conv_req make_conv(conv_type k, logic [63:0] a, logic [5:0] fl,
                                         logic [5:0] w, logic [5:0] p);
      conv_req r;
      r.kind = k;
      r.arg = a;
      {r.lj, r.zp, r.alt, r.sp, r.pl, r.hp} = fl;
      r.width = w;
      r.prec = p;
      return r;
   endfunction

   // stimulus: directed corner cases then random conversions
   initial begin
      // flag order: lj zp alt sp pl hp
      pending_convs.push_back(make_conv(CONV_C, 64'h41, 6'b000000, 6'd0, 6'd0));
      pending_convs.push_back(make_conv(CONV_C, 64'h0, 6'b100000, 6'd3, 6'd0));
      pending_convs.push_back(make_conv(CONV_C, 64'hFF, 6'b000001, 6'd0, 6'd0));
      pending_convs.push_back(make_conv(CONV_PCT, 64'h0, 6'b010000, 6'd5, 6'd0));
      pending_convs.push_back(make_conv(CONV_PCT, 64'h0, 6'b100001, 6'd4, 6'd0));
      pending_convs.push_back(make_conv(CONV_D, 64'h8000_0000, 6'b000000, 6'd0, 6'd0));
      pending_convs.push_back(make_conv(CONV_D, 64'hFFFF_FFFF_7FFF_FFFF, 6'b000010,
                                        6'd15, 6'd0));
      pending_convs.push_back(make_conv(CONV_D, 64'h0, 6'b000101, 6'd0, 6'd0));
      pending_convs.push_back(make_conv(CONV_D, 64'hFFFF_FFF6, 6'b010000, 6'd8, 6'd0));
      pending_convs.push_back(make_conv(CONV_D, 64'd42, 6'b000111, 6'd10, 6'd5));
      pending_convs.push_back(make_conv(CONV_U, 64'hFFFF_FFFF, 6'b001111, 6'd63, 6'd0));
      pending_convs.push_back(make_conv(CONV_U, 64'h0, 6'b000001, 6'd3, 6'd0));
      pending_convs.push_back(make_conv(CONV_X, 64'hDEAD_BEEF, 6'b001000, 6'd0, 6'd0));
      pending_convs.push_back(make_conv(CONV_XU, 64'hBEEF, 6'b011000, 6'd12, 6'd0));
      pending_convs.push_back(make_conv(CONV_X, 64'h0, 6'b001000, 6'd4, 6'd0));
      pending_convs.push_back(make_conv(CONV_XU, 64'hABC, 6'b101001, 6'd20, 6'd63));
      pending_convs.push_back(make_conv(CONV_P, 64'hFFFF_FFFF_FFFF_FFFF, 6'b000110,
                                        6'd0, 6'd0));
      pending_convs.push_back(make_conv(CONV_P, 64'h0, 6'b000001, 6'd0, 6'd0));
      pending_convs.push_back(make_conv(CONV_P, 64'h1234, 6'b010000, 6'd62, 6'd0));
      pending_convs.push_back(make_conv(CONV_NONE, 64'h5, 6'b111111, 6'd9, 6'd3));
      pending_convs.push_back(make_conv(CONV_D, 64'd7, 6'b100000, 6'd63, 6'd63));
      repeat (450) pending_convs.push_back(random_conv());
   end

   // calm stretch with no idling on either side
   always @(posedge clock)
      calm <= (cycle_count >= 3000 && cycle_count < 12000);

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_convs.size() != 0 && (calm || $urandom_range(0, 99) >= 17)) begin
            conv_req r;
            r = pending_convs.pop_front();
            format_conversion(r);
            req_valid           <= 1'b1;
            req_type            <= r.kind;
            req_arg_value       <= r.arg;
            req_left_justify    <= r.lj;
            req_zero_pad        <= r.zp;
            req_alt_form        <= r.alt;
            req_space_sign      <= r.sp;
            req_plus_sign       <= r.pl;
            req_field_width     <= r.width;
            req_has_precision   <= r.hp;
            req_precision_value <= r.prec;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and ready stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected word ch=%h no_char=%b last=%b", $time,
                        rsp_out_char, rsp_no_char, rsp_last_char);
               failed = 1'b1;
            end else begin
               char_word e;
               e = expected_chars.pop_front();
               if (rsp_no_char !== e.empty || rsp_last_char !== e.last ||
                   (!e.empty && rsp_out_char !== e.ch)) begin
                  $display("%0t: expected ch=%h no_char=%b last=%b, got ch=%h no_char=%b last=%b",
                           $time, e.ch, e.empty, e.last, rsp_out_char, rsp_no_char,
                           rsp_last_char);
                  failed = 1'b1;
               end
            end
         end
         rsp_ready <= calm || $urandom_range(0, 99) >= 17;
      end
   end

   initial begin
      failed = 1'b0;
      cycle_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      req_type = 3'd0;
      req_arg_value = 64'd0;
      req_left_justify = 1'b0;
      req_zero_pad = 1'b0;
      req_alt_form = 1'b0;
      req_space_sign = 1'b0;
      req_plus_sign = 1'b0;
      req_field_width = 6'd0;
      req_has_precision = 1'b0;
      req_precision_value = 6'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while ((pending_convs.size() != 0 || req_valid || expected_chars.size() != 0) &&
             cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("printf_conversion_formatter_unit test failed");
      end else begin
         repeat (200) @(posedge clock);
         if (!failed && expected_chars.size() == 0)
            $display("printf_conversion_formatter_unit test passed");
         else
            $display("printf_conversion_formatter_unit test failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/pcf_pkg.sv
src/pcf_digit_unit.sv
src/printf_conversion_formatter_unit.sv
tb/sv/printf_conversion_formatter_unit_test.sv
